>>> src/aes_cmac_tag_engine_unit_macros.svh
// Assertion macros shared by the CMAC engine modules.
// Depends on nothing; included by files that carry assertions.
`ifndef AES_CMAC_TAG_ENGINE_UNIT_MACROS_SVH
`define AES_CMAC_TAG_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ACT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("ACT check failed");
`define ACT_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error("ACT check failed");
`else
`define ACT_ASSERT(label, prop)
`define ACT_ASSERT_NEXT(label, a, b)
`endif
`endif

>>> src/act_pkg.sv
// Types, constants and AES helper functions for the CMAC tag engine.
// Depends on nothing; imported by the front, back and top modules.
package act_pkg;

  localparam logic [7:0] CmacRb  = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned BlockBytes = 16;

  typedef enum logic [1:0] {
    CfgKey0 = 2'd0,
    CfgKey1 = 2'd1,
    CfgKey2 = 2'd2,
    CfgKey3 = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    logic        status;
  } out_item_t;

  typedef enum logic [1:0] {
    OpChain = 2'd0,
    OpFinal = 2'd1,
    OpError = 2'd2
  } op_e;

  // Classified work for the back end: prepared block and operation.
  typedef struct packed {
    op_e          op;
    logic [127:0] blk;
    logic         full;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] t);
    return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
  endfunction

  // One AES round without the key addition; byte 0 sits in bits 127:120.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[c*4+i] = b[((c+i)%4)*4+i];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (final_rnd) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CmacRb : 8'h00)};
  endfunction

endpackage

>>> src/act_if.sv
// Valid/ready stream interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface act_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/act_ram.sv
// Generic RAM: one write port, registered read.
// Depends on nothing.
module act_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/act_front.sv
// Front end: accepts message blocks, pads and classifies them into jobs.
// Depends on act_pkg and act_if.
module act_front import act_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  act_if.sink  in_s,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_ready_i
);
  logic        full_q;
  job_t        job_q, job_d;
  logic [4:0]  vb;
  logic [127:0] mask, pad;

  assign in_s.ready  = !full_q || job_ready_i;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    vb = (in_s.data.valid_bytes > 5'd16) ? 5'd16 : in_s.data.valid_bytes;
    mask = '0;
    pad  = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < vb) mask[127-8*i -: 8] = 8'hff;
      if (5'(i) == vb) pad[127-8*i -: 8] = PadByte;
    end
    job_d.blk  = ({in_s.data.data_high, in_s.data.data_low} & mask) | pad;
    job_d.full = (vb == 5'd16);
    if (!in_s.data.last_block && vb != 5'd16) job_d.op = OpError;
    else if (in_s.data.last_block) job_d.op = OpFinal;
    else job_d.op = OpChain;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_s.valid && in_s.ready) begin
      full_q <= 1'b1;
    end else if (job_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) job_q <= job_d;
  end
endmodule

>>> src/act_back.sv
// Back end: key expansion, subkey derivation and iterative AES rounds.
// Depends on act_pkg, act_if, act_ram and the assertion macro header.
`include "aes_cmac_tag_engine_unit_macros.svh"
module act_back import act_pkg::*; #(
  parameter int unsigned KeyBytes = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         key_wr_i,
  input  logic [255:0] key_i,
  input  logic         job_valid_i,
  input  job_t         job_i,
  output logic         job_ready_o,
  act_if.source        out_s
);
  localparam int unsigned Nk = (KeyBytes >= 32) ? 8 : ((KeyBytes >= 24) ? 6 : 4);
  localparam int unsigned Nr = Nk + 6;
  localparam int unsigned Total = 4 * (Nr + 1);
  localparam int unsigned RkDepth = 32;
  localparam int unsigned Aw = $clog2(RkDepth);
  localparam int unsigned WiW = $clog2(Total + 1);

  typedef enum logic [2:0] {
    StIdle, StExpand, StLoad, StRound, StDone
  } state_e;

  state_e       state_q;
  logic         ready_q;
  logic [31:0]  win_q [8];
  logic [WiW-1:0] wi_q;
  logic [3:0]   wm_q;
  logic [7:0]   rcon_q;
  logic [127:0] chain_q, k1_q, k2_q, st_q;
  logic [3:0]   rnd_q;
  logic         deriving_q;
  job_t         job_q;
  logic         ov_q;
  out_item_t    out_q;
  logic [63:0]  rk_hi_q;
  logic         half_q;

  logic         we;
  logic [Aw-1:0] waddr, raddr;
  logic [63:0]  wdata, rdata;
  logic [31:0]  tmp, neww;

  act_ram #(.Width(64), .Depth(RkDepth)) u_rk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Word schedule: a sliding window of Nk words, one new word per cycle.
  always_comb begin
    tmp = win_q[Nk-1];
    if (wm_q == 4'd0) tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_q, 24'd0};
    else if (Nk > 6 && wm_q == 4'd4) tmp = sub_word(tmp);
    neww = win_q[0] ^ tmp;
  end

  // RAM port use: expand writes pairs of words; rounds read two rows per round.
  always_comb begin
    we    = 1'b0;
    waddr = Aw'((wi_q >> 1) - WiW'(1));
    wdata = {win_q[Nk-2], win_q[Nk-1]};
    raddr = '0;
    if (state_q == StExpand && wi_q[0] == 1'b0 && wi_q >= WiW'(2)) we = 1'b1;
    if (state_q == StLoad) raddr = half_q ? Aw'(1) : Aw'(0);
    if (state_q == StRound) raddr = Aw'({rnd_q, half_q});
  end

  assign job_ready_o  = (state_q == StIdle) && !ov_q && ready_q;
  assign out_s.valid  = ov_q;
  assign out_s.data   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ready_q    <= 1'b0;
      ov_q       <= 1'b0;
      chain_q    <= '0;
      deriving_q <= 1'b0;
      wi_q       <= '0;
      wm_q       <= '0;
      rnd_q      <= '0;
      half_q     <= 1'b0;
      rcon_q     <= 8'h01;
    end else begin
      if (out_s.valid && out_s.ready) ov_q <= 1'b0;
      if (key_wr_i) begin
        ready_q <= 1'b0;
        chain_q <= '0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i && !ov_q && !ready_q && !key_wr_i) begin
            for (int i = 0; i < 8; i++) win_q[i] <= key_i[255-32*i -: 32];
            wi_q   <= '0;
            wm_q   <= '0;
            rcon_q <= 8'h01;
            state_q <= StExpand;
          end else if (job_valid_i && job_ready_o) begin
            job_q <= job_i;
            if (job_i.op == OpError) begin
              chain_q <= '0;
              out_q   <= '{tag_high: '0, tag_low: '0, status: 1'b1};
              ov_q    <= 1'b1;
            end else begin
              deriving_q <= 1'b0;
              if (job_i.op == OpFinal)
                st_q <= job_i.blk ^ chain_q ^ (job_i.full ? k1_q : k2_q);
              else
                st_q <= job_i.blk ^ chain_q;
              half_q  <= 1'b0;
              state_q <= StLoad;
            end
          end
        end
        StExpand: begin
          wm_q <= (wm_q == 4'(Nk - 1)) ? 4'd0 : wm_q + 1'b1;
          // Initial key words are written first as they shift through the window.
          if (wi_q < WiW'(Nk)) begin
            for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
            win_q[Nk-1] <= win_q[0];
            wi_q <= wi_q + 1'b1;
          end else begin
            for (int i = 0; i < 7; i++) if (i < Nk - 1) win_q[i] <= win_q[i+1];
            win_q[Nk-1] <= neww;
            if (wm_q == 4'd0) rcon_q <= xtime(rcon_q);
            if (wi_q == WiW'(Total)) begin
              deriving_q <= 1'b1;
              st_q       <= '0;
              half_q     <= 1'b0;
              state_q    <= StLoad;
            end
            wi_q <= wi_q + 1'b1;
          end
        end
        StLoad: begin
          half_q <= !half_q;
          if (half_q) begin
            rk_hi_q <= rdata;
            rnd_q   <= 4'd1;
            state_q <= StRound;
          end
        end
        StRound: begin
          half_q <= !half_q;
          if (half_q) begin
            rk_hi_q <= rdata;
            rnd_q   <= rnd_q + 1'b1;
          end else begin
            if (rnd_q == 4'd1) st_q <= st_q ^ {rk_hi_q, rdata};
            else st_q <= aes_round(st_q, rnd_q == 4'(Nr + 1)) ^ {rk_hi_q, rdata};
            if (rnd_q == 4'(Nr + 1)) state_q <= StDone;
          end
        end
        StDone: begin
          if (deriving_q) begin
            k1_q    <= dbl(st_q);
            k2_q    <= dbl(dbl(st_q));
            ready_q <= 1'b1;
            state_q <= StIdle;
          end else if (job_q.op == OpFinal) begin
            if (!ov_q) begin
              out_q   <= '{tag_high: st_q[127:64], tag_low: st_q[63:0], status: 1'b0};
              ov_q    <= 1'b1;
              chain_q <= '0;
              state_q <= StIdle;
            end
          end else begin
            chain_q <= st_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ACT_ASSERT(a_no_out_overwrite, ov_q && !out_s.ready |=> ov_q && $stable(out_q))
  `ACT_ASSERT_NEXT(a_key_clears, key_wr_i, !ready_q)
  `ACT_ASSERT(a_take_only_ready, job_valid_i && job_ready_o |-> ready_q && !ov_q)
endmodule

>>> src/aes_cmac_tag_engine_unit.sv
// Top level of the AES-CMAC tag engine.
// Depends on act_pkg, act_if, act_front and act_back.
//
// The block takes 16-byte message blocks on in_s and returns one tag item on
// out_s for each last block, or an error item for a short block that is not
// last. Keys are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while idle, which the block does not enforce.
// The first block after reset or a key write starts a derivation: the round
// keys are expanded one word per cycle and L = AES(0) is computed. Afterwards
// each block is run through the AES rounds; the round unit reads its round
// key as two rows of one RAM port. A front stage holds one classified block,
// so a new block is accepted while the engine still works. A result waits in
// an output register until taken; the engine starts no new block while it
// waits. Reset clears the chain, the key registers and all valid flags, so
// the subkeys are derived anew.
module aes_cmac_tag_engine_unit import act_pkg::*; #(
  parameter int unsigned KEY_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  act_if.sink         in_s,
  act_if.source       out_s
);
  logic [63:0] key_q [4];
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgKey0: key_q[0] <= cfg_data_i;
        CfgKey1: key_q[1] <= cfg_data_i;
        CfgKey2: key_q[2] <= cfg_data_i;
        CfgKey3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  act_front u_front (
    .clk_i, .rst_ni, .in_s, .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  act_back #(.KeyBytes(KEY_BYTES)) u_back (
    .clk_i, .rst_ni, .key_wr_i(cfg_we_i),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready), .out_s
  );
endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the AES-CMAC tag engine (256-bit key).
// Depends on act_pkg and act_if; drives aes_cmac_tag_engine_unit and predicts each tag.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import act_pkg::*;

  localparam int unsigned KEY_BYTES = 32;
  localparam int NK = (KEY_BYTES >= 32) ? 8 : ((KEY_BYTES >= 24) ? 6 : 4);
  localparam int NR = NK + 6;

  class cmac_scoreboard;
    logic [63:0]  key_reg [4];
    logic [127:0] chain;
    logic [127:0] subkey1;
    logic [127:0] subkey2;
    logic [127:0] round_keys [15];
    bit           derived;
    out_item_t    tags_due [$];
    int           errors;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      chain = '0;
      subkey1 = '0;
      subkey2 = '0;
      derived = 0;
      errors = 0;
    endfunction

    function logic [7:0] gf_twice(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [31:0] sbox_word(logic [31:0] t);
      return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    function void expand_round_keys();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < NK; i++) begin
        w[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
      end
      for (int i = NK; i < 4 * (NR + 1); i++) begin
        t = w[i - 1];
        if (i % NK == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'd0};
          rcon = gf_twice(rcon);
        end else if (NK > 6 && i % NK == 4) begin
          t = sbox_word(t);
        end
        w[i] = w[i - NK] ^ t;
      end
      for (int r = 0; r <= NR; r++) begin
        round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
      end
    endfunction

    function logic [127:0] cipher(logic [127:0] x);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] v;
      v = x ^ round_keys[0];
      for (int r = 1; r <= NR; r++) begin
        for (int i = 0; i < 16; i++) s[i] = SBOX[v[127 - 8 * i -: 8]];
        for (int c = 0; c < 4; c++) begin
          for (int i = 0; i < 4; i++) t[c * 4 + i] = s[((c + i) % 4) * 4 + i];
        end
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          if (r < NR) begin
            al = a0 ^ a1 ^ a2 ^ a3;
            a0 = t[4 * c] ^ al ^ gf_twice(t[4 * c] ^ t[4 * c + 1]);
            a1 = t[4 * c + 1] ^ al ^ gf_twice(t[4 * c + 1] ^ t[4 * c + 2]);
            a2 = t[4 * c + 2] ^ al ^ gf_twice(t[4 * c + 2] ^ t[4 * c + 3]);
            a3 = t[4 * c + 3] ^ al ^ gf_twice(t[4 * c + 3] ^ t[4 * c]);
          end
          v[127 - 32 * c -: 32] = {a0, a1, a2, a3};
        end
        v = v ^ round_keys[r];
      end
      return v;
    endfunction

    function logic [127:0] gf_double(logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
    endfunction

    function void write_key(cfg_idx_e idx, logic [63:0] value);
      key_reg[idx] = value;
      derived = 0;
      chain = '0;
    endfunction

    function void note_block(in_item_t it);
      int unsigned  nbytes;
      logic [127:0] blk;
      logic [127:0] mask;
      out_item_t    res;
      nbytes = (it.valid_bytes > 16) ? 16 : it.valid_bytes;
      if (!derived) begin
        expand_round_keys();
        subkey1 = gf_double(cipher('0));
        subkey2 = gf_double(subkey1);
        derived = 1;
      end
      blk = {it.data_high, it.data_low};
      if (!it.last_block) begin
        if (nbytes < 16) begin
          chain = '0;
          res.tag_high = '0;
          res.tag_low = '0;
          res.status = 1'b1;
          tags_due.push_back(res);
        end else begin
          chain = cipher(chain ^ blk);
        end
        return;
      end
      if (nbytes == 16) begin
        blk = blk ^ subkey1;
      end else begin
        mask = (nbytes == 0) ? '0 : ~128'd0 << (128 - 8 * nbytes);
        blk = (blk & mask) | (128'h80 << (120 - 8 * nbytes));
        blk = blk ^ subkey2;
      end
      blk = cipher(blk ^ chain);
      chain = '0;
      res.tag_high = blk[127:64];
      res.tag_low = blk[63:0];
      res.status = 1'b0;
      tags_due.push_back(res);
    endfunction

    function void check_tag(out_item_t got);
      out_item_t want;
      if (tags_due.size() == 0) begin
        $error("unexpected result beat: tag_high %h tag_low %h status %b",
               got.tag_high, got.tag_low, got.status);
        errors++;
        return;
      end
      want = tags_due.pop_front();
      if (got.tag_high !== want.tag_high) begin
        $error("tag_high expected %h actual %h", want.tag_high, got.tag_high);
        errors++;
      end
      if (got.tag_low !== want.tag_low) begin
        $error("tag_low expected %h actual %h", want.tag_low, got.tag_low);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %b actual %b", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  int          src_idle;
  int          snk_idle;

  act_if #(.T(in_item_t))  in_if ();
  act_if #(.T(out_item_t)) out_if ();

  cmac_scoreboard sb = new();

  aes_cmac_tag_engine_unit #(.KEY_BYTES(KEY_BYTES)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if),
    .out_s      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      sb.check_tag(out_if.data);
    end
    out_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic send_block(logic [63:0] dh, logic [63:0] dl, logic [4:0] nb, logic lst);
    in_item_t it;
    it.data_high = dh;
    it.data_low = dl;
    it.valid_bytes = nb;
    it.last_block = lst;
    if ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_block(it);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    logic [63:0] words [4];
    words = '{k0, k1, k2, k3};
    in_if.valid <= 1'b0;
    while (sb.tags_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= words[i];
      @(posedge clk_i);
      sb.write_key(cfg_idx_e'(i), words[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_messages(int count);
    int sent;
    int chain_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_block(rand64(), rand64(), 5'($urandom_range(31)), 1'b0);
        sent++;
      end else begin
        chain_len = $urandom_range(4);
        for (int j = 0; j < chain_len; j++) begin
          send_block(rand64(), rand64(), 5'd16, 1'b0);
        end
        send_block(rand64(), rand64(),
                   5'(($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(16)),
                   1'b1);
        sent += chain_len + 1;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgKey0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    src_idle = 24;
    snk_idle = 50;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_key('0, '0, '0, '0);
    send_block('0, '0, 5'd0, 1'b1);
    send_block('1, '1, 5'd1, 1'b1);
    send_block('1, '1, 5'd7, 1'b1);
    send_block('1, '1, 5'd8, 1'b1);
    send_block('1, '1, 5'd9, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('1, '1, 5'd16, 1'b1);
    send_block('0, '0, 5'd16, 1'b1);
    send_block(rand64(), rand64(), 5'd31, 1'b1);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd5, 1'b1);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block('1, '1, 5'd15, 1'b0);
    send_block(rand64(), rand64(), 5'd0, 1'b0);
    send_block(rand64(), rand64(), 5'd20, 1'b0);
    send_block(rand64(), rand64(), 5'd16, 1'b1);
    random_messages(350);

    load_key('1, '1, '1, '1);
    src_idle = 50;
    snk_idle = 24;
    random_messages(400);

    load_key(rand64(), rand64(), rand64(), rand64());
    src_idle = 0;
    snk_idle = 0;
    random_messages(400);

    load_key(rand64(), rand64(), rand64(), rand64());
    random_messages(350);

    in_if.valid <= 1'b0;
    while (sb.tags_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/act_pkg.sv
src/act_if.sv
src/act_ram.sv
src/act_front.sv
src/act_back.sv
src/aes_cmac_tag_engine_unit.sv
verif/tb_top.sv
